>>> design/rlkd_pkg.sv
// Shared types and constants for the resistor ladder key debouncer.
`timescale 1ns / 1ps
package rlkd_pkg;

	localparam int WINDOW_COUNT = 5;
	localparam int BOUND_BITS   = 12;
	localparam int WINDOW_BITS  = 2 * BOUND_BITS;
	localparam int COUNT_BITS   = 8;
	localparam int CODE_BITS    = 3;
	localparam int REG_COUNT    = 8;
	localparam int ADDR_BITS    = 5;
	localparam int DATA_BITS    = 32;

	typedef logic [CODE_BITS-1:0]   key_code_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [WINDOW_BITS-1:0] window_t;
	typedef window_t [WINDOW_COUNT-1:0] window_array_t;

	typedef enum logic [2:0] {
		REG_WINDOW_VOLUME_DOWN = 3'd0,
		REG_WINDOW_VOLUME_UP   = 3'd1,
		REG_WINDOW_SEEK_DOWN   = 3'd2,
		REG_WINDOW_SEEK_UP     = 3'd3,
		REG_WINDOW_MODE_KEY    = 3'd4,
		REG_CONFIRM_COUNT      = 3'd5,
		REG_MAX_COUNT          = 3'd6,
		REG_LONG_PRESS_TICKS   = 3'd7
	} reg_index_t;

	localparam window_t RST_WINDOW_VOLUME_DOWN = 24'd258071;
	localparam window_t RST_WINDOW_VOLUME_UP   = 24'd553055;
	localparam window_t RST_WINDOW_SEEK_DOWN   = 24'd1745282;
	localparam window_t RST_WINDOW_SEEK_UP     = 24'd1016016;
	localparam window_t RST_WINDOW_MODE_KEY    = 24'd2917024;
	localparam count_t  RST_CONFIRM_COUNT      = 8'd2;
	localparam count_t  RST_MAX_COUNT          = 8'd3;
	localparam count_t  RST_LONG_PRESS_TICKS   = 8'd100;

	localparam key_code_t KEY_NONE = 3'd0;

	// Debounce settings handed to the back end.
	typedef struct packed {
		count_t confirm_count;
		count_t max_count;
		count_t long_press_ticks;
	} debounce_cfg_t;

	typedef struct packed {
		key_code_t key_code;
		logic      short_press;
		logic      long_press;
	} result_t;

endpackage

>>> design/resistor_ladder_key_debouncer.sv
// Top level of the resistor ladder key debouncer with its register file.
`timescale 1ns / 1ps
// Usage:
//   Samples enter through a queue-style port: adc_sample is taken at a clock
//   edge where push is high and full is low. Each sample gives exactly one
//   result (key_code, short_press, long_press), shown while empty is low and
//   taken at an edge where pop is high.
//   The front end classifies a sample in the cycle it is accepted and writes
//   the key code to a two-entry queue; the back end updates the debounce state
//   and writes the result to a two-entry result queue. A result is visible
//   once its key code has left the code queue and entered the result queue;
//   one sample per clock is sustained while the receiver keeps popping.
//   When the receiver stops popping, the result queue fills, the back end
//   holds, then the code queue fills and full rises; nothing is dropped.
//   Reset (arst_n low) empties both queues, clears the held key, counter and
//   timer, and loads the default windows and thresholds. Registers are written
//   over the APB port at byte address 4*index by the user, only while no
//   sample is in flight, unenforced by the block; pready is always high.
module resistor_ladder_key_debouncer
	import rlkd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	output logic                   full,
	input  logic                   pop,
	output logic                   empty,
	output logic [CODE_BITS-1:0]   key_code,
	output logic                   short_press,
	output logic                   long_press,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_BITS-1:0]   paddr,
	input  logic [DATA_BITS-1:0]   pwdata,
	output logic [DATA_BITS-1:0]   prdata,
	output logic                   pready
);

	window_array_t windows_q;
	debounce_cfg_t cfg_q;
	reg_index_t    reg_idx;
	logic          reg_write;

	key_code_t     front_code;
	logic          code_empty;
	key_code_t     code_head;
	logic          code_take;
	logic          result_full;
	logic          result_push;
	result_t       result_in;
	result_t       result_head;

	assign pready    = 1'b1;
	assign reg_idx   = reg_index_t'(paddr[ADDR_BITS-1:2]);
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			windows_q[0]           <= RST_WINDOW_VOLUME_DOWN;
			windows_q[1]           <= RST_WINDOW_VOLUME_UP;
			windows_q[2]           <= RST_WINDOW_SEEK_DOWN;
			windows_q[3]           <= RST_WINDOW_SEEK_UP;
			windows_q[4]           <= RST_WINDOW_MODE_KEY;
			cfg_q.confirm_count    <= RST_CONFIRM_COUNT;
			cfg_q.max_count        <= RST_MAX_COUNT;
			cfg_q.long_press_ticks <= RST_LONG_PRESS_TICKS;
		end else if (reg_write) begin
			unique case (reg_idx)
				REG_WINDOW_VOLUME_DOWN: windows_q[0] <= pwdata[WINDOW_BITS-1:0];
				REG_WINDOW_VOLUME_UP:   windows_q[1] <= pwdata[WINDOW_BITS-1:0];
				REG_WINDOW_SEEK_DOWN:   windows_q[2] <= pwdata[WINDOW_BITS-1:0];
				REG_WINDOW_SEEK_UP:     windows_q[3] <= pwdata[WINDOW_BITS-1:0];
				REG_WINDOW_MODE_KEY:    windows_q[4] <= pwdata[WINDOW_BITS-1:0];
				REG_CONFIRM_COUNT:      cfg_q.confirm_count <= pwdata[COUNT_BITS-1:0];
				REG_MAX_COUNT:          cfg_q.max_count <= pwdata[COUNT_BITS-1:0];
				REG_LONG_PRESS_TICKS:   cfg_q.long_press_ticks <= pwdata[COUNT_BITS-1:0];
				default:                ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_VOLUME_DOWN: prdata = DATA_BITS'(windows_q[0]);
			REG_WINDOW_VOLUME_UP:   prdata = DATA_BITS'(windows_q[1]);
			REG_WINDOW_SEEK_DOWN:   prdata = DATA_BITS'(windows_q[2]);
			REG_WINDOW_SEEK_UP:     prdata = DATA_BITS'(windows_q[3]);
			REG_WINDOW_MODE_KEY:    prdata = DATA_BITS'(windows_q[4]);
			REG_CONFIRM_COUNT:      prdata = DATA_BITS'(cfg_q.confirm_count);
			REG_MAX_COUNT:          prdata = DATA_BITS'(cfg_q.max_count);
			REG_LONG_PRESS_TICKS:   prdata = DATA_BITS'(cfg_q.long_press_ticks);
			default:                prdata = '0;
		endcase
	end

	rlkd_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.adc_sample(adc_sample),
		.windows   (windows_q),
		.key_code  (front_code)
	);

	rlkd_fifo #(
		.WIDTH(CODE_BITS)
	) u_code_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (front_code),
		.full  (full),
		.pop   (code_take),
		.rdata (code_head),
		.empty (code_empty)
	);

	rlkd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.code_valid (!code_empty),
		.code       (code_head),
		.code_take  (code_take),
		.result_full(result_full),
		.result_push(result_push),
		.result     (result_in)
	);

	rlkd_fifo #(
		.WIDTH($bits(result_t))
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (result_push),
		.wdata (result_in),
		.full  (result_full),
		.pop   (pop),
		.rdata (result_head),
		.empty (empty)
	);

	assign key_code    = result_head.key_code;
	assign short_press = result_head.short_press;
	assign long_press  = result_head.long_press;

endmodule

>>> design/rlkd_fifo.sv
// Two-entry queue used between front and back and at the result side.
`timescale 1ns / 1ps
module rlkd_fifo #(
	parameter int WIDTH = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/rlkd_front.sv
// Front end: classifies a sample against the five key windows.
`timescale 1ns / 1ps
module rlkd_front
	import rlkd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  window_array_t          windows,
	output key_code_t              key_code
);

	localparam int CMP_BITS = (SAMPLE_BITS > BOUND_BITS) ? SAMPLE_BITS : BOUND_BITS;

	logic [CMP_BITS-1:0]     sample_ext;
	logic [WINDOW_COUNT-1:0] hit;

	assign sample_ext = CMP_BITS'(adc_sample);

	always_comb begin
		for (int k = 0; k < WINDOW_COUNT; k++) begin
			hit[k] = (sample_ext >= CMP_BITS'(windows[k][BOUND_BITS-1:0]))
				&& (sample_ext <= CMP_BITS'(windows[k][WINDOW_BITS-1:BOUND_BITS]));
		end
	end

	// Lowest-numbered window wins on overlap: scan downward so it is assigned last.
	always_comb begin
		key_code = KEY_NONE;
		for (int k = WINDOW_COUNT - 1; k >= 0; k--) begin
			if (hit[k]) begin
				key_code = CODE_BITS'(k + 1);
			end
		end
	end

endmodule

>>> design/rlkd_back.sv
// Back end: agreement counter, hold timer and press detection.
`timescale 1ns / 1ps
module rlkd_back
	import rlkd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  debounce_cfg_t cfg,
	input  logic          code_valid,
	input  key_code_t     code,
	output logic          code_take,
	input  logic          result_full,
	output logic          result_push,
	output result_t       result
);

	key_code_t held_key_q;
	count_t    agree_count_q;
	count_t    hold_timer_q;

	logic      agree;
	count_t    count_next;
	logic      short_hit;
	logic      long_hit;

	assign code_take   = code_valid && !result_full;
	assign result_push = code_take;
	assign agree       = (code == held_key_q);

	always_comb begin
		if (agree) begin
			count_next = (agree_count_q < cfg.max_count) ? agree_count_q + 8'd1
				: agree_count_q;
		end else begin
			count_next = (agree_count_q != '0) ? agree_count_q - 8'd1 : agree_count_q;
		end
	end

	assign short_hit = agree && (count_next == cfg.confirm_count);
	assign long_hit  = agree && (hold_timer_q == cfg.long_press_ticks);

	assign result.key_code    = code;
	assign result.short_press = short_hit && (code != KEY_NONE);
	assign result.long_press  = long_hit && (code != KEY_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_key_q    <= KEY_NONE;
			agree_count_q <= '0;
			hold_timer_q  <= '0;
		end else if (code_take) begin
			agree_count_q <= count_next;
			if (agree) begin
				hold_timer_q <= hold_timer_q + 8'd1;
			end else begin
				hold_timer_q <= '0;
				// switch keys only once the old one has drained
				if (count_next == '0) begin
					held_key_q <= code;
				end
			end
		end
	end

endmodule
